[design/hysteresis_heater_with_cook_timer_unit_defines.svh]
// Assertion macros for the hysteresis heater with cook timer unit.
// Included by the top level; needs nothing else.
`ifndef HYSTERESIS_HEATER_WITH_COOK_TIMER_UNIT_DEFINES_SVH
`define HYSTERESIS_HEATER_WITH_COOK_TIMER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define HHCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define HHCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/hhct_pkg.sv]
// Types and constants of the hysteresis heater with cook timer unit.
// Used by the channel interfaces, the step logic and the top level.
package hhct_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned BEEP_TICKS       = 1000;
  localparam int unsigned PRESC_W          = 10;
  localparam int unsigned BEEP_W           = 10;
  localparam int unsigned CNT_W            = 7;
  localparam int unsigned TEMP_W           = 13;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 8;

  // Samples below one degree are treated as a broken sensor
  localparam logic signed [TEMP_W:0] FAULT_LIMIT_TENTHS = 14'sd10;

  // Lamp pattern bits
  localparam logic [2:0] LAMP_RED   = 3'b001;
  localparam logic [2:0] LAMP_GREEN = 3'b010;
  localparam logic [2:0] LAMP_BLUE  = 3'b100;

  // Reset values of the configuration registers
  localparam logic [7:0] TARGET_RESET = 8'd134;
  localparam logic [6:0] COOK_RESET   = 7'd30;
  localparam logic [5:0] HYST_RESET   = 6'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_COOK   = 2'd1,
    CFG_HYST   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] target_degrees;
    logic [6:0] cook_seconds;
    logic [5:0] hysteresis_tenths;
  } hhct_cfg_t;

  typedef struct packed {
    logic                     sample_valid;
    logic signed [TEMP_W-1:0] temperature_tenths;
    logic                     lid_closed;
    logic                     start_stop_press;
  } hhct_item_t;

  typedef struct packed {
    logic               run_mode;
    logic               heating;
    logic               fault_seen;
    logic               blink_phase;
    logic [2:0]         lamp_pattern;
    logic               target_reached;
    logic [CNT_W-1:0]   countdown;
    logic [PRESC_W-1:0] prescaler;
    logic [BEEP_W-1:0]  beep_remaining;
  } hhct_state_t;

  typedef struct packed {
    logic             heater_on;
    logic             running;
    logic             sensor_fault;
    logic             led_red;
    logic             led_green;
    logic             led_blue;
    logic             buzzer_on;
    logic [CNT_W-1:0] seconds_left;
  } hhct_result_t;

endpackage

[design/hhct_channels.sv]
// Valid/ready channel interfaces of the heater unit: input, result and config write.
// Depends on hhct_pkg for field widths.
interface hhct_in_if;
  logic                               valid;
  logic                               ready;
  logic                               sample_valid;
  logic signed [hhct_pkg::TEMP_W-1:0] temperature_tenths;
  logic                               lid_closed;
  logic                               start_stop_press;

  modport source (output valid, output sample_valid, output temperature_tenths,
                  output lid_closed, output start_stop_press, input ready);
  modport sink (input valid, input sample_valid, input temperature_tenths,
                input lid_closed, input start_stop_press, output ready);
endinterface

interface hhct_out_if;
  logic                        valid;
  logic                        ready;
  logic                        heater_on;
  logic                        running;
  logic                        sensor_fault;
  logic                        led_red;
  logic                        led_green;
  logic                        led_blue;
  logic                        buzzer_on;
  logic [hhct_pkg::CNT_W-1:0]  seconds_left;

  modport source (output valid, output heater_on, output running, output sensor_fault,
                  output led_red, output led_green, output led_blue, output buzzer_on,
                  output seconds_left, input ready);
  modport sink (input valid, input heater_on, input running, input sensor_fault,
                input led_red, input led_green, input led_blue, input buzzer_on,
                input seconds_left, output ready);
endinterface

interface hhct_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hhct_pkg::CFG_IDX_W-1:0]   index;
  logic [hhct_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/hhct_step.sv]
// One millisecond tick of the heater controller: next state and result.
// Purely combinational; depends on hhct_pkg.
module hhct_step (
  input  hhct_pkg::hhct_cfg_t    cfg,
  input  hhct_pkg::hhct_state_t  st,
  input  hhct_pkg::hhct_item_t   item,
  output hhct_pkg::hhct_state_t  st_nxt,
  output hhct_pkg::hhct_result_t res
);

  logic [11:0]                      tgt_u;
  logic signed [hhct_pkg::TEMP_W:0] temp_w;
  logic signed [hhct_pkg::TEMP_W:0] tgt_w;
  logic signed [hhct_pkg::TEMP_W:0] hyst_w;
  logic signed [hhct_pkg::TEMP_W:0] off_lim;
  logic signed [hhct_pkg::TEMP_W:0] on_lim;
  logic [hhct_pkg::PRESC_W:0]       pre_inc;

  // Scale target to tenths and build the hysteresis band
  assign tgt_u   = 12'(cfg.target_degrees) * 12'd10;
  assign temp_w  = {item.temperature_tenths[hhct_pkg::TEMP_W-1], item.temperature_tenths};
  assign tgt_w   = $signed({2'b00, tgt_u});
  assign hyst_w  = $signed({8'b0, cfg.hysteresis_tenths});
  assign off_lim = tgt_w + hyst_w;
  assign on_lim  = tgt_w - hyst_w;
  assign pre_inc = {1'b0, st.prescaler} + 11'd1;

  always_comb begin
    st_nxt = st;

    // Toggle run on a press
    if (item.start_stop_press) begin
      st_nxt.run_mode = !st.run_mode;
    end

    // Reload with lid open, else count seconds once the target was reached
    if (!item.lid_closed) begin
      st_nxt.countdown = cfg.cook_seconds;
      st_nxt.prescaler = '0;
    end else if (st.countdown != '0 && st.target_reached) begin
      if (pre_inc >= 11'(hhct_pkg::TICKS_PER_SECOND)) begin
        st_nxt.countdown = st.countdown - 7'd1;
        st_nxt.prescaler = '0;
      end else begin
        st_nxt.prescaler = pre_inc[hhct_pkg::PRESC_W-1:0];
      end
    end

    // Expire the target beep
    if (st.beep_remaining != '0) begin
      st_nxt.beep_remaining = st.beep_remaining - 10'd1;
    end

    // Evaluate a new sample
    if (item.sample_valid) begin
      if (temp_w < hhct_pkg::FAULT_LIMIT_TENTHS) begin
        st_nxt.heating      = 1'b0;
        st_nxt.run_mode     = 1'b0;
        st_nxt.fault_seen   = 1'b1;
        st_nxt.lamp_pattern = st.blink_phase ? hhct_pkg::LAMP_RED : hhct_pkg::LAMP_BLUE;
      end else begin
        st_nxt.fault_seen = 1'b0;
        if (st_nxt.run_mode) begin
          // Turn-off test first, so zero hysteresis at target ends up on
          if (temp_w >= off_lim && st.heating) begin
            st_nxt.heating = 1'b0;
          end
          if (temp_w <= on_lim) begin
            st_nxt.heating = 1'b1;
          end
        end else begin
          st_nxt.heating   = 1'b0;
          st_nxt.countdown = cfg.cook_seconds;
          st_nxt.prescaler = '0;
        end
        if (st_nxt.run_mode && st_nxt.heating) begin
          st_nxt.lamp_pattern = hhct_pkg::LAMP_RED;
        end else if (st_nxt.run_mode) begin
          st_nxt.lamp_pattern = hhct_pkg::LAMP_GREEN;
        end else begin
          st_nxt.lamp_pattern = hhct_pkg::LAMP_BLUE;
        end
        // Latch first reach of target and start the beep
        if (!st.target_reached && temp_w >= tgt_w) begin
          st_nxt.target_reached = 1'b1;
          st_nxt.beep_remaining = hhct_pkg::BEEP_W'(hhct_pkg::BEEP_TICKS);
        end
      end
      st_nxt.blink_phase = !st.blink_phase;
    end
  end

  // Map the new state onto the result fields
  always_comb begin
    res.heater_on    = st_nxt.heating;
    res.running      = st_nxt.run_mode;
    res.sensor_fault = st_nxt.fault_seen;
    res.led_red      = |(st_nxt.lamp_pattern & hhct_pkg::LAMP_RED);
    res.led_green    = |(st_nxt.lamp_pattern & hhct_pkg::LAMP_GREEN);
    res.led_blue     = |(st_nxt.lamp_pattern & hhct_pkg::LAMP_BLUE);
    res.buzzer_on    = (st_nxt.beep_remaining != '0) || (st_nxt.countdown == 7'd1);
    res.seconds_left = st_nxt.countdown;
  end

endmodule

[design/hysteresis_heater_with_cook_timer_unit.sv]
// Hysteresis heater with cook timer: top level with channel registers and state.
// Each accepted input transaction passes through the input register and then the
// result register; one transaction per cycle while the receiver takes results, and
// the tick logic between the two registers updates the controller state combinationally.
// Reset (rst_n low, synchronous): pipeline empty, config to defaults, stopped,
// heater off, blue lamp, countdown at 30 s, no beep.
`include "hysteresis_heater_with_cook_timer_unit_defines.svh"

module hysteresis_heater_with_cook_timer_unit (
  input  logic        clk,
  input  logic        rst_n,
  hhct_in_if.sink     in_ch,
  hhct_out_if.source  out_ch,
  hhct_cfg_if.sink    cfg_ch
);

  hhct_pkg::hhct_cfg_t    cfg_r;
  hhct_pkg::hhct_state_t  state_r;
  hhct_pkg::hhct_state_t  state_nxt;
  hhct_pkg::hhct_item_t   s1_item_r;
  hhct_pkg::hhct_item_t   in_item;
  hhct_pkg::hhct_result_t res_nxt;
  hhct_pkg::hhct_result_t out_res_r;
  logic                   s1_v_r;
  logic                   s1_v_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   advance;
  logic                   in_take;

  // Handshake control: the input stage moves whenever the result register frees up
  assign advance      = s1_v_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    s1_v_nxt      = in_take || (s1_v_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_ch.ready);
  end

  assign in_item.sample_valid       = in_ch.sample_valid;
  assign in_item.temperature_tenths = in_ch.temperature_tenths;
  assign in_item.lid_closed         = in_ch.lid_closed;
  assign in_item.start_stop_press   = in_ch.start_stop_press;

  hhct_step u_step (
    .cfg    (cfg_r),
    .st     (state_r),
    .item   (s1_item_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_degrees    <= hhct_pkg::TARGET_RESET;
      cfg_r.cook_seconds      <= hhct_pkg::COOK_RESET;
      cfg_r.hysteresis_tenths <= hhct_pkg::HYST_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        hhct_pkg::CFG_TARGET: cfg_r.target_degrees    <= cfg_ch.data;
        hhct_pkg::CFG_COOK:   cfg_r.cook_seconds      <= cfg_ch.data[6:0];
        hhct_pkg::CFG_HYST:   cfg_r.hysteresis_tenths <= cfg_ch.data[5:0];
        default: ;
      endcase
    end
  end

  // Controller state advances once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.run_mode       <= 1'b0;
      state_r.heating        <= 1'b0;
      state_r.fault_seen     <= 1'b0;
      state_r.blink_phase    <= 1'b0;
      state_r.lamp_pattern   <= hhct_pkg::LAMP_BLUE;
      state_r.target_reached <= 1'b0;
      state_r.countdown      <= hhct_pkg::COOK_RESET;
      state_r.prescaler      <= '0;
      state_r.beep_remaining <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input and result payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.heater_on    = out_res_r.heater_on;
  assign out_ch.running      = out_res_r.running;
  assign out_ch.sensor_fault = out_res_r.sensor_fault;
  assign out_ch.led_red      = out_res_r.led_red;
  assign out_ch.led_green    = out_res_r.led_green;
  assign out_ch.led_blue     = out_res_r.led_blue;
  assign out_ch.buzzer_on    = out_res_r.buzzer_on;
  assign out_ch.seconds_left = out_res_r.seconds_left;

  // A fault always leaves the heater off until a good sample
  `HHCT_ASSERT_SAME(a_fault_heater_off, clk, rst_n, state_r.fault_seen,
                    !state_r.heating, "heater on during sensor fault")
  // A beep only runs after the target latch is set
  `HHCT_ASSERT_SAME(a_beep_after_target, clk, rst_n, state_r.beep_remaining != '0,
                    state_r.target_reached, "beep without target reached")
  // An accepted transaction always lands in the input stage
  `HHCT_ASSERT_NEXT(a_take_fills_stage, clk, rst_n, in_take, s1_v_r,
                    "accepted transaction lost")

endmodule

[tb/sv/tb_hysteresis_heater_with_cook_timer_unit.sv]
// Self-checking testbench for the hysteresis heater with cook timer unit.
// Drives tick transactions, predicts each result in step with the inputs and
// compares it field by field. Depends on hhct_pkg and the channel interfaces.
module tb_hysteresis_heater_with_cook_timer_unit;

  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n;

  hhct_in_if  in_if();
  hhct_out_if out_if();
  hhct_cfg_if cfg_if();

  hysteresis_heater_with_cook_timer_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Predicted controller state and register copies
  hhct_pkg::hhct_state_t heater_st;
  logic [7:0]  cfg_target;
  logic [6:0]  cfg_cook;
  logic [5:0]  cfg_hyst;

  hhct_pkg::hhct_item_t   pending_ticks[$];
  hhct_pkg::hhct_result_t expected_outputs[$];
  hhct_pkg::hhct_item_t   driven_tick;

  int tx_idle_pct = 30;
  int rx_idle_pct = 72;
  logic rx_hold = 1'b0;
  int ticks_accepted = 0;
  int error_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the predicted state by one tick and return the expected outputs
  function automatic hhct_pkg::hhct_result_t advance_heater(input hhct_pkg::hhct_item_t t);
    int temp;
    int tgt;
    int band;
    hhct_pkg::hhct_result_t r;
    temp = {{(32 - hhct_pkg::TEMP_W){t.temperature_tenths[hhct_pkg::TEMP_W-1]}},
            t.temperature_tenths};
    tgt  = int'(cfg_target) * 10;
    band = int'(cfg_hyst);

    if (t.start_stop_press) heater_st.run_mode = !heater_st.run_mode;

    // Reload while the lid is open, else count seconds once the target was hit
    if (!t.lid_closed) begin
      heater_st.countdown = cfg_cook;
      heater_st.prescaler = '0;
    end else if (heater_st.countdown != 0 && heater_st.target_reached) begin
      if (int'(heater_st.prescaler) + 1 >= int'(hhct_pkg::TICKS_PER_SECOND)) begin
        heater_st.countdown = heater_st.countdown - 1'b1;
        heater_st.prescaler = '0;
      end else begin
        heater_st.prescaler = heater_st.prescaler + 1'b1;
      end
    end

    if (heater_st.beep_remaining != 0)
      heater_st.beep_remaining = heater_st.beep_remaining - 1'b1;

    if (t.sample_valid) begin
      if (temp < int'(hhct_pkg::FAULT_LIMIT_TENTHS)) begin
        // Broken sensor: stop, heater off, alternate blue and red
        heater_st.heating      = 1'b0;
        heater_st.run_mode     = 1'b0;
        heater_st.fault_seen   = 1'b1;
        heater_st.lamp_pattern = heater_st.blink_phase ? hhct_pkg::LAMP_RED
                                                       : hhct_pkg::LAMP_BLUE;
      end else begin
        heater_st.fault_seen = 1'b0;
        if (heater_st.run_mode) begin
          // Turn-off test first, so a zero band at the target leaves it on
          if (temp >= tgt + band && heater_st.heating) heater_st.heating = 1'b0;
          if (temp <= tgt - band) heater_st.heating = 1'b1;
        end else begin
          heater_st.heating   = 1'b0;
          heater_st.countdown = cfg_cook;
          heater_st.prescaler = '0;
        end
        if (heater_st.run_mode && heater_st.heating)
          heater_st.lamp_pattern = hhct_pkg::LAMP_RED;
        else if (heater_st.run_mode)
          heater_st.lamp_pattern = hhct_pkg::LAMP_GREEN;
        else
          heater_st.lamp_pattern = hhct_pkg::LAMP_BLUE;
        if (!heater_st.target_reached && temp >= tgt) begin
          heater_st.target_reached = 1'b1;
          heater_st.beep_remaining = hhct_pkg::BEEP_W'(hhct_pkg::BEEP_TICKS);
        end
      end
      heater_st.blink_phase = !heater_st.blink_phase;
    end

    r.heater_on    = heater_st.heating;
    r.running      = heater_st.run_mode;
    r.sensor_fault = heater_st.fault_seen;
    r.led_red      = |(heater_st.lamp_pattern & hhct_pkg::LAMP_RED);
    r.led_green    = |(heater_st.lamp_pattern & hhct_pkg::LAMP_GREEN);
    r.led_blue     = |(heater_st.lamp_pattern & hhct_pkg::LAMP_BLUE);
    r.buzzer_on    = (heater_st.beep_remaining != 0) || (heater_st.countdown == 1);
    r.seconds_left = heater_st.countdown;
    return r;
  endfunction

  function automatic hhct_pkg::hhct_item_t make_tick(input logic sv, input int temp,
                                                     input logic lid, input logic press);
    hhct_pkg::hhct_item_t t;
    t.sample_valid       = sv;
    t.temperature_tenths = temp[hhct_pkg::TEMP_W-1:0];
    t.lid_closed         = lid;
    t.start_stop_press   = press;
    return t;
  endfunction

  // Mostly samples around the hysteresis band, some near the fault limit,
  // some anywhere in the 13-bit range
  function automatic hhct_pkg::hhct_item_t random_tick();
    int tgt;
    int band;
    int sel;
    int temp;
    tgt  = int'(cfg_target) * 10;
    band = int'(cfg_hyst) + 4;
    sel  = $urandom_range(0, 99);
    if (sel < 85) temp = tgt - band + int'($urandom_range(0, 2 * band));
    else if (sel < 90) temp = int'($urandom_range(0, 20)) - 5;
    else temp = int'($urandom_range(0, 8191)) - 4096;
    return make_tick($urandom_range(0, 99) < 60, temp, $urandom_range(0, 99) < 90,
                     $urandom_range(0, 99) < 6);
  endfunction

  task automatic queue_random(input int n);
    repeat (n) pending_ticks.push_back(random_tick());
  endtask

  // Hold until every queued tick is accepted and every result has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_ticks.size() != 0 || in_if.valid || expected_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input hhct_pkg::cfg_reg_t idx, input logic [7:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      hhct_pkg::CFG_TARGET: cfg_target = value;
      hhct_pkg::CFG_COOK:   cfg_cook   = value[6:0];
      hhct_pkg::CFG_HYST:   cfg_hyst   = value[5:0];
      default: ;
    endcase
  endtask

  // Driver: record the accepted transaction, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_outputs.push_back(advance_heater(driven_tick));
        ticks_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          driven_tick = pending_ticks.pop_front();
          in_if.valid              <= 1'b1;
          in_if.sample_valid       <= driven_tick.sample_valid;
          in_if.temperature_tenths <= driven_tick.temperature_tenths;
          in_if.lid_closed         <= driven_tick.lid_closed;
          in_if.start_stop_press   <= driven_tick.start_stop_press;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction
  always @(posedge clk) begin
    hhct_pkg::hhct_result_t got;
    hhct_pkg::hhct_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{heater_on: out_if.heater_on, running: out_if.running,
                sensor_fault: out_if.sensor_fault, led_red: out_if.led_red,
                led_green: out_if.led_green, led_blue: out_if.led_blue,
                buzzer_on: out_if.buzzer_on, seconds_left: out_if.seconds_left};
        if (expected_outputs.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = expected_outputs.pop_front();
          if (got.heater_on !== want.heater_on || got.running !== want.running ||
              got.sensor_fault !== want.sensor_fault || got.led_red !== want.led_red ||
              got.led_green !== want.led_green || got.led_blue !== want.led_blue ||
              got.buzzer_on !== want.buzzer_on || got.seconds_left !== want.seconds_left) begin
            error_count++;
            if (error_count <= 10)
              $display({"mismatch: expected heater=%b run=%b fault=%b rgb=%b%b%b buzz=%b ",
                        "secs=%0d, got heater=%b run=%b fault=%b rgb=%b%b%b buzz=%b secs=%0d"},
                       want.heater_on, want.running, want.sensor_fault, want.led_red,
                       want.led_green, want.led_blue, want.buzzer_on, want.seconds_left,
                       got.heater_on, got.running, got.sensor_fault, got.led_red,
                       got.led_green, got.led_blue, got.buzzer_on, got.seconds_left);
          end
        end
      end
      out_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    while (ticks_accepted < 80) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (60) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    // Known values on every input, predictor at its reset state
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample_valid = 1'b0;
    in_if.temperature_tenths = '0;
    in_if.lid_closed = 1'b0;
    in_if.start_stop_press = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = hhct_pkg::CFG_TARGET;
    cfg_if.data = '0;
    cfg_target = hhct_pkg::TARGET_RESET;
    cfg_cook   = hhct_pkg::COOK_RESET;
    cfg_hyst   = hhct_pkg::HYST_RESET;
    heater_st  = '0;
    heater_st.lamp_pattern = hhct_pkg::LAMP_BLUE;
    heater_st.countdown    = hhct_pkg::COOK_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: band edges, first reach and beep, both fault blink phases,
    // fault limit, field extremes, presses and lid
    pending_ticks.push_back(make_tick(1'b0, 0, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 500, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 1200, 1'b1, 1'b1));
    pending_ticks.push_back(make_tick(1'b1, 1335, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 1344, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 1345, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 1336, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 1335, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 9, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 9, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 10, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, -4096, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 4095, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, -400, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 3000, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b0, 0, 1'b1, 1'b1));
    pending_ticks.push_back(make_tick(1'b1, 9, 1'b1, 1'b1));
    pending_ticks.push_back(make_tick(1'b0, -1, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 2000, 1'b1, 1'b1));
    wait_drained();

    // Zero band: at exactly the target the heater ends up on
    write_reg(hhct_pkg::CFG_HYST, 8'd0);
    pending_ticks.push_back(make_tick(1'b1, 1000, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 1340, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 1341, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(1'b1, 1340, 1'b1, 1'b0));
    wait_drained();

    // Default settings, sender sparse and receiver sparser; pause midway
    write_reg(hhct_pkg::CFG_TARGET, 8'd134);
    write_reg(hhct_pkg::CFG_COOK, 8'd30);
    write_reg(hhct_pkg::CFG_HYST, 8'd5);
    tx_idle_pct = 30;
    rx_idle_pct = 72;
    queue_random(75);
    wait_drained();
    queue_random(75);
    wait_drained();

    // Low extremes, idling swapped
    write_reg(hhct_pkg::CFG_TARGET, 8'd100);
    write_reg(hhct_pkg::CFG_COOK, 8'd10);
    write_reg(hhct_pkg::CFG_HYST, 8'd0);
    tx_idle_pct = 72;
    rx_idle_pct = 30;
    queue_random(125);
    wait_drained();

    // High extremes, no idling from here on
    write_reg(hhct_pkg::CFG_TARGET, 8'd160);
    write_reg(hhct_pkg::CFG_COOK, 8'd90);
    write_reg(hhct_pkg::CFG_HYST, 8'd50);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(125);
    wait_drained();

    // One-second countdown: reload with the lid open, start the run, then
    // keep the lid shut past a full second so it reaches zero
    write_reg(hhct_pkg::CFG_TARGET, 8'd0);
    write_reg(hhct_pkg::CFG_COOK, 8'd1);
    write_reg(hhct_pkg::CFG_HYST, 8'd63);
    pending_ticks.push_back(make_tick(1'b0, 0, 1'b0, !heater_st.run_mode));
    repeat (1050)
      pending_ticks.push_back(make_tick(1'($urandom_range(0, 1)),
                                        10 + int'($urandom_range(0, 3000)), 1'b1, 1'b0));
    queue_random(50);
    wait_drained();

    // Register widths at their top: cook written with bit 7 set
    write_reg(hhct_pkg::CFG_TARGET, 8'd255);
    write_reg(hhct_pkg::CFG_COOK, 8'hFF);
    write_reg(hhct_pkg::CFG_HYST, 8'd63);
    queue_random(100);
    wait_drained();

    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_outputs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
